FILE: src/cclk_pkg.sv
// ----------------------------------------------------------------------------
// cclk_pkg: shared types, limits and helpers for the calendar clock core
// payload structs of the transfer channels and small bcd conversion helpers
// ----------------------------------------------------------------------------
package cclk_pkg;

    // load range limits, compared against the raw bcd bytes
    localparam logic [7:0] SEC_MAX_BCD  = 8'h59;
    localparam logic [7:0] MIN_MAX_BCD  = 8'h59;
    localparam logic [7:0] HOUR_MAX_BCD = 8'h23;
    localparam logic [7:0] WDAY_MAX_RAW = 8'd7;
    localparam logic [7:0] DAY_MAX_BCD  = 8'h31;
    localparam logic [7:0] MON_MAX_BCD  = 8'h12;

    // counter limits in binary
    localparam logic [5:0]  SEC_LAST   = 6'd59;
    localparam logic [5:0]  MIN_LAST   = 6'd59;
    localparam logic [4:0]  HOUR_LAST  = 5'd23;
    localparam logic [2:0]  WDAY_LAST  = 3'd7;
    localparam logic [2:0]  WDAY_FIRST = 3'd1;
    localparam logic [5:0]  DAY_LONG   = 6'd31;
    localparam logic [5:0]  DAY_SHORT  = 6'd30;
    localparam logic [5:0]  DAY_FIRST  = 6'd1;
    localparam logic [3:0]  MON_LAST   = 4'd12;
    localparam logic [3:0]  MON_FIRST  = 4'd1;
    localparam logic [11:0] YEAR_BASE  = 12'd2000;
    localparam logic [11:0] YEAR_MAX   = 12'hfff;
    localparam logic [6:0]  YMOD_LAST  = 7'd99;
    localparam logic [7:0]  CENTURY    = 8'd100;

    // tens-digit masks of the rtc register image
    localparam logic [7:0] LO_NIBBLE = 8'h0f;
    localparam logic [7:0] MASK_SEC  = 8'hf0;
    localparam logic [7:0] MASK_MIN  = 8'hf0;
    localparam logic [7:0] MASK_HOUR = 8'h30;
    localparam logic [7:0] MASK_DAY  = 8'h30;
    localparam logic [7:0] MASK_MON  = 8'h10;
    localparam logic [7:0] MASK_YEAR = 8'hff;

    // mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] bcd_seconds;
        logic [7:0] bcd_minutes;
        logic [7:0] bcd_hours;
        logic [7:0] raw_weekday;
        logic [7:0] bcd_day;
        logic [7:0] bcd_month;
        logic [7:0] bcd_year;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  sec_now;
        logic [5:0]  min_now;
        logic [4:0]  hour_now;
        logic [2:0]  weekday_now;
        logic [5:0]  day_now;
        logic [3:0]  month_now;
        logic [11:0] year_now;
        logic [55:0] bcd_image;
        logic        load_failed;
        logic [15:0] error_total;
    } t_out_item;

    // 10*hi + lo, nibbles taken as they are (max 165)
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // two bcd digits of a value below 100, tens by reciprocal multiply
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  ones;
        prod     = {8'd0, v} * 15'd205;
        tens     = prod[14:11];
        tens_x10 = ({3'd0, tens} << 3) + ({3'd0, tens} << 1);
        ones     = v - tens_x10;
        return {tens, ones[3:0]};
    endfunction

    function automatic logic is_long_month(input logic [3:0] m);
        return (m == 4'd1) || (m == 4'd3) || (m == 4'd5) || (m == 4'd7) ||
               (m == 4'd8) || (m == 4'd10) || (m == 4'd12);
    endfunction

endpackage

FILE: src/cclk_if.sv
// ----------------------------------------------------------------------------
// cclk channel interfaces
// valid/ready channels that carry one input item or one result item
// ----------------------------------------------------------------------------
interface cclk_in_if import cclk_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cclk_out_if import cclk_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/calendar_clock_with_bcd_load_core.sv
// ----------------------------------------------------------------------------
// calendar_clock_with_bcd_load_core: binary calendar clock with rtc bcd load
// one result per input item: the time after the item and its rtc byte image
// ----------------------------------------------------------------------------
// The core keeps seconds, minutes, hours, weekday, day, month and year. A tick
// item (mode 0) adds one second with carries up to the year; months 1, 3, 5,
// 7, 8, 10 and 12 last 31 days, every other month 30. A load item (mode 1)
// checks the raw rtc bytes in the order seconds, minutes, hours, weekday, day,
// month; fields before the first failing check are taken, the rest keep their
// value, and a failure bumps a 16-bit error counter. The year is taken only
// when every check passes. Each transfer in produces one transfer out, carrying
// the binary time, a seven-byte bcd register image and the error status. One
// item is accepted every cycle: the next state and the image come from one pass
// of logic into the result register, and the input stays ready while that
// register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module calendar_clock_with_bcd_load_core import cclk_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cclk_in_if.sink       i_in,
    cclk_out_if.source    o_out
);

    // calendar state
    logic [5:0]  r_sec,  n_sec;
    logic [5:0]  r_min,  n_min;
    logic [4:0]  r_hour, n_hour;
    logic [2:0]  r_wday, n_wday;
    logic [5:0]  r_day,  n_day;
    logic [3:0]  r_mon,  n_mon;
    logic [11:0] r_year, n_year;
    // year modulo 100, tracked next to the year so the image needs no divider
    logic [6:0]  r_ymod, n_ymod;
    logic [15:0] r_err,  n_err;
    logic        n_fail;

    // result register
    t_out_item   r_out, n_out;
    logic        r_out_valid;

    logic        in_xfer;

    // load checks, chained so a field is only taken if all earlier ones pass
    logic        take_sec, take_min, take_hour, take_wday, take_day, take_all;
    logic [7:0]  ld_sec, ld_min, ld_hour, ld_day, ld_mon, ld_year;
    logic [5:0]  last_day;

    // result register is free or being emptied this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign take_sec  = (i_in.data.bcd_seconds <= SEC_MAX_BCD);
    assign take_min  = take_sec  && (i_in.data.bcd_minutes <= MIN_MAX_BCD);
    assign take_hour = take_min  && (i_in.data.bcd_hours   <= HOUR_MAX_BCD);
    assign take_wday = take_hour && (i_in.data.raw_weekday <= WDAY_MAX_RAW);
    assign take_day  = take_wday && (i_in.data.bcd_day     <= DAY_MAX_BCD);
    assign take_all  = take_day  && (i_in.data.bcd_month   <= MON_MAX_BCD);

    assign ld_sec  = bcd_to_bin(i_in.data.bcd_seconds);
    assign ld_min  = bcd_to_bin(i_in.data.bcd_minutes);
    assign ld_hour = bcd_to_bin(i_in.data.bcd_hours);
    assign ld_day  = bcd_to_bin(i_in.data.bcd_day);
    assign ld_mon  = bcd_to_bin(i_in.data.bcd_month);
    assign ld_year = bcd_to_bin(i_in.data.bcd_year);

    // month 0 and the out-of-range months count as short months
    assign last_day = is_long_month(r_mon) ? DAY_LONG : DAY_SHORT;

    // next calendar state for the item at the input
    always_comb begin
        n_sec  = r_sec;
        n_min  = r_min;
        n_hour = r_hour;
        n_wday = r_wday;
        n_day  = r_day;
        n_mon  = r_mon;
        n_year = r_year;
        n_ymod = r_ymod;
        n_err  = r_err;
        n_fail = 1'b0;
        if (i_in.data.mode == MODE_LOAD) begin
            if (take_sec)  n_sec  = ld_sec[5:0];
            if (take_min)  n_min  = ld_min[5:0];
            if (take_hour) n_hour = ld_hour[4:0];
            if (take_wday) n_wday = i_in.data.raw_weekday[2:0];
            if (take_day)  n_day  = ld_day[5:0];
            if (take_all) begin
                n_mon  = ld_mon[3:0];
                // base year is a multiple of 100, the loaded offset is below 200
                n_year = YEAR_BASE + {4'd0, ld_year};
                n_ymod = (ld_year >= CENTURY) ? 7'(ld_year - CENTURY) : ld_year[6:0];
            end else begin
                n_fail = 1'b1;
                n_err  = r_err + 16'd1;
            end
        end else begin
            // one-second tick, each counter wraps at or above its limit
            if (r_sec < SEC_LAST) begin
                n_sec = r_sec + 6'd1;
            end else begin
                n_sec = '0;
                if (r_min < MIN_LAST) begin
                    n_min = r_min + 6'd1;
                end else begin
                    n_min = '0;
                    if (r_hour < HOUR_LAST) begin
                        n_hour = r_hour + 5'd1;
                    end else begin
                        n_hour = '0;
                        n_wday = (r_wday < WDAY_LAST) ? r_wday + 3'd1 : WDAY_FIRST;
                        if (r_day < last_day) begin
                            n_day = r_day + 6'd1;
                        end else begin
                            n_day = DAY_FIRST;
                            if (r_mon < MON_LAST) begin
                                n_mon = r_mon + 4'd1;
                            end else begin
                                n_mon  = MON_FIRST;
                                n_year = r_year + 12'd1;
                                // the 12-bit year wraps from 4095 (95) to 0
                                if (r_year == YEAR_MAX || r_ymod == YMOD_LAST) begin
                                    n_ymod = '0;
                                end else begin
                                    n_ymod = r_ymod + 7'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // result built from the state after the item
    always_comb begin
        n_out             = r_out;
        n_out.sec_now     = n_sec;
        n_out.min_now     = n_min;
        n_out.hour_now    = n_hour;
        n_out.weekday_now = n_wday;
        n_out.day_now     = n_day;
        n_out.month_now   = n_mon;
        n_out.year_now    = n_year;
        n_out.load_failed = n_fail;
        n_out.error_total = n_err;
        n_out.bcd_image   = {
            bin_to_bcd(n_ymod)               & (MASK_YEAR | LO_NIBBLE),
            bin_to_bcd({3'd0, n_mon})        & (MASK_MON  | LO_NIBBLE),
            bin_to_bcd({1'd0, n_day})        & (MASK_DAY  | LO_NIBBLE),
            {5'd0, n_wday},
            bin_to_bcd({2'd0, n_hour})       & (MASK_HOUR | LO_NIBBLE),
            bin_to_bcd({1'd0, n_min})        & (MASK_MIN  | LO_NIBBLE),
            bin_to_bcd({1'd0, n_sec})        & (MASK_SEC  | LO_NIBBLE)
        };
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_wday      <= WDAY_FIRST;
            r_day       <= DAY_FIRST;
            r_mon       <= MON_FIRST;
            r_year      <= YEAR_BASE;
            r_ymod      <= '0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_sec  <= n_sec;
                r_min  <= n_min;
                r_hour <= n_hour;
                r_wday <= n_wday;
                r_day  <= n_day;
                r_mon  <= n_mon;
                r_year <= n_year;
                r_ymod <= n_ymod;
                r_err  <= n_err;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

    // every accepted item shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted item produced no result");

    // error count only moves on a failed load
    a_err_only_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_xfer && i_in.data.mode == MODE_LOAD && !take_all) |=> $stable(r_err))
        else $error("error counter changed without a failed load");

    // a failed load reports the bumped counter
    a_fail_reports_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.data.mode == MODE_LOAD && !take_all) |=>
            (r_out.load_failed && r_out.error_total == r_err))
        else $error("failed load result inconsistent with counter");

    // year modulo tracker stays in range
    a_ymod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ymod <= YMOD_LAST)
        else $error("year modulo tracker out of range");

    // a tick never fails
    a_tick_no_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.data.mode == MODE_TICK) |=> !r_out.load_failed)
        else $error("tick flagged as failed load");

endmodule
